// File: sv/opm_pkg.sv
package opm_pkg;

   // Field widths
   localparam int SAMPLE_W  = 12;
   localparam int GAIN_W    = 24;
   localparam int Q_W       = 32;
   localparam int VOLT_W    = 28;
   localparam int CSR_IDX_W = 2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_VOLTS_PER_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_AMPS_PER_VOLT   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LOAD_OHMS       = 2'd2;

   // Register reset values
   localparam logic [GAIN_W-1:0] VOLTS_PER_COUNT_RST = 24'd13520;
   localparam logic [GAIN_W-1:0] AMPS_PER_VOLT_RST   = 24'd65536;
   localparam logic [GAIN_W-1:0] LOAD_OHMS_RST       = 24'd65536;

   localparam logic [Q_W-1:0] Q_MAX = '1;

   typedef struct packed {
      logic [GAIN_W-1:0] volts_per_count;
      logic [GAIN_W-1:0] amps_per_volt;
      logic [GAIN_W-1:0] load_ohms;
   } csr_regs_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] mean_raw;
      logic [Q_W-1:0]      sensed_volts;
      logic [Q_W-1:0]      filtered_current;
      logic [Q_W-1:0]      filtered_load_volts;
      logic [Q_W-1:0]      power_estimate;
   } result_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_MEAN,
      BK_VOLT,
      BK_SCALE,
      BK_SUM,
      BK_FILT,
      BK_POWER,
      BK_OUT
   } back_state_type;

endpackage

// File: sv/opm_front.sv
module opm_front #(
   parameter int OVERSAMPLE = 16,
   parameter int ACC_W      = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   output logic                          full,
   input  logic [opm_pkg::SAMPLE_W-1:0]  raw_sample,
   input  opm_pkg::queue_status_type     q_status,
   output logic                          q_push,
   output logic [ACC_W-1:0]              q_data
);
   import opm_pkg::*;

   localparam int CNT_W = (OVERSAMPLE > 1) ? $clog2(OVERSAMPLE) : 1;
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(OVERSAMPLE - 1);

   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [ACC_W-1:0] acc_ff, acc_in;
   logic [ACC_W-1:0] acc_sum;
   logic             last;
   logic             take;

   // Stall only the closing sample of a group, and only while the queue is full
   assign last    = (cnt_ff == CNT_LAST);
   assign full    = last & q_status.full;
   assign take    = push & ~full;
   assign acc_sum = acc_ff + ACC_W'(raw_sample);

   // Hand the finished group sum to the back end
   assign q_push = take & last;
   assign q_data = acc_sum;

   // Advance the group count and accumulator
   always_comb begin
      cnt_in = cnt_ff;
      acc_in = acc_ff;
      if (take) begin
         if (last) begin
            cnt_in = '0;
            acc_in = '0;
         end else begin
            cnt_in = cnt_ff + 1'b1;
            acc_in = acc_sum;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         acc_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         acc_ff <= acc_in;
      end
   end

endmodule

// File: sv/opm_queue.sv
module opm_queue #(
   parameter int DW = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [DW-1:0]              wdata,
   input  logic                       pop,
   output logic [DW-1:0]              rdata,
   output opm_pkg::queue_status_type  status
);
   import opm_pkg::*;

   logic [DW-1:0] slot_ff [2];
   logic          wr_ptr_ff, wr_ptr_in;
   logic          rd_ptr_ff, rd_ptr_in;
   logic [1:0]    cnt_ff, cnt_in;
   logic          do_push;
   logic          do_pop;

   assign status.empty = (cnt_ff == 2'd0);
   assign status.full  = (cnt_ff == 2'd2);
   assign do_push      = push & ~status.full;
   assign do_pop       = pop & ~status.empty;
   assign rdata        = slot_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Store the incoming group sum
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

// File: sv/opm_cdiv.sv
module opm_cdiv #(
   parameter int DW      = 16,
   parameter int DIVISOR = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] dividend,
   output logic          done,
   output logic [DW-1:0] quotient
);
   import opm_pkg::*;

   generate
      if ((DIVISOR & (DIVISOR - 1)) == 0) begin : g_shift
         localparam int SH = $clog2(DIVISOR);

         logic [DW-1:0] q_ff;
         logic          done_ff;

         // Power-of-two divisor: one shift, ready the next cycle
         always_ff @(posedge clock) begin
            if (start) begin
               q_ff <= dividend >> SH;
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               done_ff <= 1'b0;
            end else begin
               done_ff <= start;
            end
         end

         assign done     = done_ff;
         assign quotient = q_ff;
      end else begin : g_recip
         // Multiply by a rounded-up reciprocal and keep the top bits; exact for every
         // DW-bit dividend. The product is built from four half-width partial products.
         localparam int L   = $clog2(DIVISOR);
         localparam int S   = DW + L;
         localparam int MB  = DW + 1;
         localparam int XLW = (DW + 1) / 2;
         localparam int MLW = (MB + 1) / 2;
         localparam int PRW = XLW + MLW;
         localparam int AW  = DW + MB;
         localparam logic [MB-1:0]  RECIP    = MB'((64'd1 << S) / 64'(DIVISOR) + 64'd1);
         localparam logic [MLW-1:0] RECIP_LO = RECIP[MLW-1:0];
         localparam logic [MLW-1:0] RECIP_HI = MLW'(RECIP[MB-1:MLW]);
         localparam logic [1:0]     STEP_LAST = 2'd3;

         logic [DW-1:0]  x_ff;
         logic [AW-1:0]  acc_ff;
         logic [AW-1:0]  acc_in;
         logic [DW-1:0]  q_ff;
         logic [1:0]     step_ff;
         logic           busy_ff;
         logic           done_ff;
         logic [XLW-1:0] op_a;
         logic [MLW-1:0] op_b;
         logic [PRW-1:0] pp;
         logic [AW-1:0]  term;

         // Pick one half of the dividend and one half of the reciprocal per step
         assign op_a = step_ff[0] ? XLW'(x_ff[DW-1:XLW]) : x_ff[XLW-1:0];
         assign op_b = step_ff[1] ? RECIP_HI : RECIP_LO;
         assign pp   = PRW'(op_a) * PRW'(op_b);

         // Place the partial product at its weight
         always_comb begin
            case (step_ff)
               2'd0:    term = AW'(pp);
               2'd1:    term = AW'(pp) << XLW;
               2'd2:    term = AW'(pp) << MLW;
               default: term = AW'(pp) << (XLW + MLW);
            endcase
         end

         assign acc_in = acc_ff + term;

         always_ff @(posedge clock) begin
            if (start) begin
               x_ff   <= dividend;
               acc_ff <= '0;
            end else if (busy_ff) begin
               acc_ff <= acc_in;
            end
            if (busy_ff && (step_ff == STEP_LAST)) begin
               q_ff <= DW'(acc_in[AW-1:S]);
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               busy_ff <= 1'b0;
               step_ff <= '0;
               done_ff <= 1'b0;
            end else begin
               done_ff <= busy_ff && (step_ff == STEP_LAST);
               if (start) begin
                  busy_ff <= 1'b1;
                  step_ff <= '0;
               end else if (busy_ff) begin
                  if (step_ff == STEP_LAST) begin
                     busy_ff <= 1'b0;
                  end
                  step_ff <= step_ff + 1'b1;
               end
            end
         end

         assign done     = done_ff;
         assign quotient = q_ff;
      end
   endgenerate

endmodule

// File: sv/opm_back.sv
module opm_back #(
   parameter int WINDOW     = 8,
   parameter int OVERSAMPLE = 16,
   parameter int ACC_W      = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  opm_pkg::csr_regs_type      csr,
   input  opm_pkg::queue_status_type  q_status,
   input  logic [ACC_W-1:0]           q_data,
   output logic                       q_pop,
   input  logic                       rsp_pop,
   output logic                       rsp_valid,
   output opm_pkg::result_type        rsp
);
   import opm_pkg::*;

   localparam int SUM_W = Q_W + $clog2(WINDOW);
   localparam int PW    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam logic [PW-1:0] POS_LAST = PW'(WINDOW - 1);
   localparam int VPROD_W = SAMPLE_W + GAIN_W;
   localparam int SPROD_W = VOLT_W + GAIN_W;
   localparam int PPROD_W = 2 * Q_W;

   back_state_type state_ff, state_in;

   logic             filt_start;
   logic             rsp_load;
   logic             mean_done;
   logic [ACC_W-1:0] mean_q;
   logic             cur_done;
   logic [SUM_W-1:0] cur_q;
   logic             load_done;
   logic [SUM_W-1:0] load_q;

   logic [SAMPLE_W-1:0] mean_ff;
   logic [VOLT_W-1:0]   volts_ff;
   logic [Q_W-1:0]      cur_ff;
   logic [Q_W-1:0]      load_ff;
   logic [Q_W-1:0]      curf_ff;
   logic [Q_W-1:0]      loadf_ff;
   logic [Q_W-1:0]      power_ff;

   logic [SUM_W-1:0] cur_sum_ff, cur_sum_in;
   logic [SUM_W-1:0] load_sum_ff, load_sum_in;
   logic [PW-1:0]    pos_ff, pos_in;
   logic [WINDOW-1:0] vld_ff;

   logic [2*Q_W-1:0] hist_mem [WINDOW];
   logic [2*Q_W-1:0] hist_rd_ff;
   logic             vld_rd_ff;
   logic [Q_W-1:0]   old_cur;
   logic [Q_W-1:0]   old_load;

   logic [VPROD_W-1:0] vprod;
   logic [SPROD_W-1:0] cprod;
   logic [SPROD_W-1:0] lprod;
   logic [PPROD_W-1:0] pprod;
   logic [SPROD_W-17:0] cur_wide;
   logic [SPROD_W-17:0] load_wide;
   logic [PPROD_W-17:0] power_wide;
   logic [Q_W-1:0]      cur_sat;
   logic [Q_W-1:0]      load_sat;
   logic [Q_W-1:0]      power_sat;

   result_type rsp_ff;
   logic       rsp_valid_ff;

   // Dividers: group mean, then both window averages side by side
   opm_cdiv #(.DW(ACC_W), .DIVISOR(OVERSAMPLE)) u_mean_div (
      .clock    (clock),
      .reset    (reset),
      .start    (q_pop),
      .dividend (q_data),
      .done     (mean_done),
      .quotient (mean_q)
   );

   opm_cdiv #(.DW(SUM_W), .DIVISOR(WINDOW)) u_cur_div (
      .clock    (clock),
      .reset    (reset),
      .start    (filt_start),
      .dividend (cur_sum_in),
      .done     (cur_done),
      .quotient (cur_q)
   );

   opm_cdiv #(.DW(SUM_W), .DIVISOR(WINDOW)) u_load_div (
      .clock    (clock),
      .reset    (reset),
      .start    (filt_start),
      .dividend (load_sum_in),
      .done     (load_done),
      .quotient (load_q)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE:  if (!q_status.empty) state_in = BK_MEAN;
         BK_MEAN:  if (mean_done) state_in = BK_VOLT;
         BK_VOLT:  state_in = BK_SCALE;
         BK_SCALE: state_in = BK_SUM;
         BK_SUM:   state_in = BK_FILT;
         BK_FILT:  if (cur_done && load_done) state_in = BK_POWER;
         BK_POWER: state_in = BK_OUT;
         BK_OUT:   if (!rsp_valid_ff || rsp_pop) state_in = BK_IDLE;
         default:  state_in = BK_IDLE;
      endcase
   end

   // Sequencer outputs
   always_comb begin
      q_pop      = 1'b0;
      filt_start = 1'b0;
      rsp_load   = 1'b0;
      case (state_ff)
         BK_IDLE: q_pop      = !q_status.empty;
         BK_SUM:  filt_start = 1'b1;
         BK_OUT:  rsp_load   = !rsp_valid_ff || rsp_pop;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Scaling products, truncated to Q16.16; current, load and power are also saturated
   assign vprod      = VPROD_W'(mean_ff) * VPROD_W'(csr.volts_per_count);
   assign cprod      = SPROD_W'(volts_ff) * SPROD_W'(csr.amps_per_volt);
   assign lprod      = SPROD_W'(volts_ff) * SPROD_W'(csr.load_ohms);
   assign pprod      = PPROD_W'(curf_ff) * PPROD_W'(loadf_ff);
   assign cur_wide   = cprod[SPROD_W-1:16];
   assign load_wide  = lprod[SPROD_W-1:16];
   assign power_wide = pprod[PPROD_W-1:16];
   assign cur_sat    = (|cur_wide[SPROD_W-17:Q_W]) ? Q_MAX : cur_wide[Q_W-1:0];
   assign load_sat   = (|load_wide[SPROD_W-17:Q_W]) ? Q_MAX : load_wide[Q_W-1:0];
   assign power_sat  = (|power_wide[PPROD_W-17:Q_W]) ? Q_MAX : power_wide[Q_W-1:0];

   always_ff @(posedge clock) begin
      if (state_ff == BK_MEAN && mean_done) begin
         mean_ff <= mean_q[SAMPLE_W-1:0];
      end
      if (state_ff == BK_VOLT) begin
         volts_ff <= vprod[VPROD_W-1:8];
      end
      if (state_ff == BK_SCALE) begin
         cur_ff  <= cur_sat;
         load_ff <= load_sat;
      end
      if (state_ff == BK_FILT && cur_done) begin
         curf_ff  <= cur_q[Q_W-1:0];
         loadf_ff <= load_q[Q_W-1:0];
      end
      if (state_ff == BK_POWER) begin
         power_ff <= power_sat;
      end
   end

   // Entry that leaves the window; a slot never written counts as zero
   assign old_cur  = vld_rd_ff ? hist_rd_ff[2*Q_W-1:Q_W] : '0;
   assign old_load = vld_rd_ff ? hist_rd_ff[Q_W-1:0] : '0;

   // Running sums and window slot
   always_comb begin
      cur_sum_in  = cur_sum_ff - SUM_W'(old_cur) + SUM_W'(cur_ff);
      load_sum_in = load_sum_ff - SUM_W'(old_load) + SUM_W'(load_ff);
      pos_in      = (pos_ff == POS_LAST) ? '0 : pos_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_sum_ff  <= '0;
         load_sum_ff <= '0;
         pos_ff      <= '0;
         vld_ff      <= '0;
      end else if (state_ff == BK_SUM) begin
         cur_sum_ff     <= cur_sum_in;
         load_sum_ff    <= load_sum_in;
         pos_ff         <= pos_in;
         vld_ff[pos_ff] <= 1'b1;
      end
   end

   // History memory: registered read at the current slot, write on update
   always_ff @(posedge clock) begin
      hist_rd_ff <= hist_mem[pos_ff];
      vld_rd_ff  <= vld_ff[pos_ff];
      if (state_ff == BK_SUM) begin
         hist_mem[pos_ff] <= {cur_ff, load_ff};
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_ff.mean_raw            <= mean_ff;
         rsp_ff.sensed_volts        <= Q_W'(volts_ff);
         rsp_ff.filtered_current    <= curf_ff;
         rsp_ff.filtered_load_volts <= loadf_ff;
         rsp_ff.power_estimate      <= power_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_pop) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

// File: sv/oversampled_power_monitor_core.sv
// A group sum passes the queue, then the back end's mean divider and its volts, scale,
// sum, window-average, power and output states; a divider whose divisor is not a power
// of two multiplies by a reciprocal instead of shifting.
// Throughput: one sample a cycle while the back end keeps pace; a two-entry group queue
// absorbs short stalls.
// Reset: synchronous, active high; clears counts, sums and history valid bits, loads defaults.
module oversampled_power_monitor_core #(
   parameter int WINDOW     = 8,
   parameter int OVERSAMPLE = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_push,
   output logic                           req_full,
   input  logic [opm_pkg::SAMPLE_W-1:0]   req_raw_sample,
   output logic                           rsp_empty,
   input  logic                           rsp_pop,
   output logic [opm_pkg::SAMPLE_W-1:0]   rsp_mean_raw,
   output logic [opm_pkg::Q_W-1:0]        rsp_sensed_volts,
   output logic [opm_pkg::Q_W-1:0]        rsp_filtered_current,
   output logic [opm_pkg::Q_W-1:0]        rsp_filtered_load_volts,
   output logic [opm_pkg::Q_W-1:0]        rsp_power_estimate,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [opm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [opm_pkg::GAIN_W-1:0]     csr_wdata
);
   import opm_pkg::*;

   localparam int ACC_W = SAMPLE_W + $clog2(OVERSAMPLE);

   csr_regs_type     csr_ff;
   queue_status_type q_status;
   logic             q_push;
   logic [ACC_W-1:0] q_wdata;
   logic             q_pop;
   logic [ACC_W-1:0] q_rdata;
   logic             rsp_valid;
   result_type       rsp;

   // Configuration registers; unknown indexes are dropped
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.volts_per_count <= VOLTS_PER_COUNT_RST;
         csr_ff.amps_per_volt   <= AMPS_PER_VOLT_RST;
         csr_ff.load_ohms       <= LOAD_OHMS_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_VOLTS_PER_COUNT: csr_ff.volts_per_count <= csr_wdata;
            CSR_AMPS_PER_VOLT:   csr_ff.amps_per_volt   <= csr_wdata;
            CSR_LOAD_OHMS:       csr_ff.load_ohms       <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Front end: group accumulation
   opm_front #(.OVERSAMPLE(OVERSAMPLE), .ACC_W(ACC_W)) u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (req_push),
      .full       (req_full),
      .raw_sample (req_raw_sample),
      .q_status   (q_status),
      .q_push     (q_push),
      .q_data     (q_wdata)
   );

   // Group sums waiting for the back end
   opm_queue #(.DW(ACC_W)) u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (q_push),
      .wdata  (q_wdata),
      .pop    (q_pop),
      .rdata  (q_rdata),
      .status (q_status)
   );

   // Back end: scaling, boxcar filters and power
   opm_back #(.WINDOW(WINDOW), .OVERSAMPLE(OVERSAMPLE), .ACC_W(ACC_W)) u_back (
      .clock     (clock),
      .reset     (reset),
      .csr       (csr_ff),
      .q_status  (q_status),
      .q_data    (q_rdata),
      .q_pop     (q_pop),
      .rsp_pop   (rsp_pop),
      .rsp_valid (rsp_valid),
      .rsp       (rsp)
   );

   assign rsp_empty               = ~rsp_valid;
   assign rsp_mean_raw            = rsp.mean_raw;
   assign rsp_sensed_volts        = rsp.sensed_volts;
   assign rsp_filtered_current    = rsp.filtered_current;
   assign rsp_filtered_load_volts = rsp.filtered_load_volts;
   assign rsp_power_estimate      = rsp.power_estimate;

   // A completed group never meets a full queue
   a_queue_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_status.full)
      else $error("group sum pushed into a full queue");

   // The back end only takes a group sum that is there
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_status.empty)
      else $error("back end popped an empty queue");

   // Input stalls only when the queue is full
   a_full_cause: assert property (@(posedge clock) disable iff (reset)
      req_full |-> q_status.full)
      else $error("input stalled with room in the queue");

endmodule

// File: bench/oversampled_power_monitor_core_tb.sv
module oversampled_power_monitor_core_tb;
   import opm_pkg::*;

   localparam int WINDOW        = 8;
   localparam int OVERSAMPLE    = 16;
   localparam int SETTLE_CYCLES = 32;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int GROUPS_PER_PHASE = 8;

   // Index past the last register: the block must ignore writes to it
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam logic [GAIN_W-1:0]    GAIN_MAX   = '1;

   // Edge-case readings for the first group: extremes and alternating bits
   localparam logic [16*SAMPLE_W-1:0] EDGE_SAMPLES = {
      12'hFFF, 12'h000, 12'hAAA, 12'h555, 12'hFFF, 12'h000, 12'h001, 12'h800,
      12'h7FF, 12'hFFE, 12'hFFF, 12'hFFF, 12'hFFF, 12'h000, 12'h000, 12'h3C3
   };

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_push = 1'b0;
   logic                  req_full;
   logic [SAMPLE_W-1:0]   req_raw_sample = '0;
   logic                  rsp_empty;
   logic                  rsp_pop = 1'b0;
   logic [SAMPLE_W-1:0]   rsp_mean_raw;
   logic [Q_W-1:0]        rsp_sensed_volts;
   logic [Q_W-1:0]        rsp_filtered_current;
   logic [Q_W-1:0]        rsp_filtered_load_volts;
   logic [Q_W-1:0]        rsp_power_estimate;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [GAIN_W-1:0]     csr_wdata = '0;

   // Gains and filter state of the monitor as this bench sees them
   logic [GAIN_W-1:0] gain_volts_per_count;
   logic [GAIN_W-1:0] gain_amps_per_volt;
   logic [GAIN_W-1:0] gain_load_ohms;
   logic [7:0]        samples_in_group;
   logic [19:0]       group_total;
   logic [Q_W-1:0]    amps_history [WINDOW];
   logic [Q_W-1:0]    load_history [WINDOW];
   logic [34:0]       amps_total;
   logic [34:0]       load_total;
   logic [2:0]        history_slot;

   result_type pending_readings [$];
   result_type oldest_reading;

   int cycle_count    = 0;
   int mismatch_count = 0;
   int samples_sent   = 0;
   int readings_seen  = 0;
   int reg_writes     = 0;
   int send_idle_pct  = 0;
   int pop_stall_pct  = 0;

   oversampled_power_monitor_core #(
      .WINDOW     (WINDOW),
      .OVERSAMPLE (OVERSAMPLE)
   ) DUT (
      .clock                   (clock),
      .reset                   (reset),
      .req_push                (req_push),
      .req_full                (req_full),
      .req_raw_sample          (req_raw_sample),
      .rsp_empty               (rsp_empty),
      .rsp_pop                 (rsp_pop),
      .rsp_mean_raw            (rsp_mean_raw),
      .rsp_sensed_volts        (rsp_sensed_volts),
      .rsp_filtered_current    (rsp_filtered_current),
      .rsp_filtered_load_volts (rsp_filtered_load_volts),
      .rsp_power_estimate      (rsp_power_estimate),
      .csr_valid               (csr_valid),
      .csr_ready               (csr_ready),
      .csr_index               (csr_index),
      .csr_wdata               (csr_wdata)
   );

   always #10 clock = ~clock;

   // Abort a run that goes past the cycle limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d readings outstanding",
                  cycle_count, pending_readings.size());
         $display("** oversampled_power_monitor_core: FAILED **");
         $finish;
      end
   end

   task automatic report_mismatch(input string what);
      $display("Mismatch at cycle %0d: %s", cycle_count, what);
      mismatch_count++;
   endtask

   function automatic logic [Q_W-1:0] clamp_q16(input logic [63:0] v);
      return (v > 64'hFFFF_FFFF) ? Q_MAX : v[Q_W-1:0];
   endfunction

   function automatic void reset_monitor_state();
      gain_volts_per_count = VOLTS_PER_COUNT_RST;
      gain_amps_per_volt   = AMPS_PER_VOLT_RST;
      gain_load_ohms       = LOAD_OHMS_RST;
      samples_in_group     = '0;
      group_total          = '0;
      amps_total           = '0;
      load_total           = '0;
      history_slot         = '0;
      for (int i = 0; i < WINDOW; i++) begin
         amps_history[i] = '0;
         load_history[i] = '0;
      end
   endfunction

   // Fold one reading into the group; on the closing reading, scale, filter
   // and queue the expected result
   function automatic void accumulate_sample(input logic [SAMPLE_W-1:0] s);
      logic [63:0]    mean;
      logic [63:0]    volts;
      logic [Q_W-1:0] amps;
      logic [Q_W-1:0] load;
      logic [Q_W-1:0] amps_avg;
      logic [Q_W-1:0] load_avg;
      result_type     r;
      group_total      = group_total + 20'(s);
      samples_in_group = samples_in_group + 8'd1;
      if (samples_in_group >= OVERSAMPLE) begin
         mean  = 64'(group_total) / OVERSAMPLE;
         volts = (mean * gain_volts_per_count) >> 8;
         amps  = clamp_q16((volts * gain_amps_per_volt) >> 16);
         load  = clamp_q16((volts * gain_load_ohms) >> 16);
         samples_in_group = '0;
         group_total      = '0;
         amps_total = amps_total - amps_history[history_slot] + amps;
         load_total = load_total - load_history[history_slot] + load;
         amps_history[history_slot] = amps;
         load_history[history_slot] = load;
         history_slot = history_slot + 3'd1;
         amps_avg = clamp_q16(64'(amps_total) / WINDOW);
         load_avg = clamp_q16(64'(load_total) / WINDOW);
         r.mean_raw            = mean[SAMPLE_W-1:0];
         r.sensed_volts        = volts[Q_W-1:0];
         r.filtered_current    = amps_avg;
         r.filtered_load_volts = load_avg;
         r.power_estimate      = clamp_q16((64'(amps_avg) * load_avg) >> 16);
         pending_readings.push_back(r);
      end
   endfunction

   // Offer one reading, idling first at the current rate; hold it until taken
   task automatic send_sample(input logic [SAMPLE_W-1:0] s);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push       <= 1'b1;
      req_raw_sample <= s;
      @(posedge clock);
      while (req_full) @(posedge clock);
      accumulate_sample(s);
      samples_sent++;
   endtask

   // Drop the request, wait for every reading and let the back end go quiet
   task automatic settle_pipeline();
      req_push <= 1'b0;
      @(posedge clock);
      while (pending_readings.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [GAIN_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_VOLTS_PER_COUNT: gain_volts_per_count = value;
         CSR_AMPS_PER_VOLT:   gain_amps_per_volt   = value;
         CSR_LOAD_OHMS:       gain_load_ohms       = value;
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
      reg_writes++;
   endtask

   task automatic write_gains(input logic [GAIN_W-1:0] vpc,
                              input logic [GAIN_W-1:0] apv,
                              input logic [GAIN_W-1:0] ohms);
      settle_pipeline();
      write_register(CSR_VOLTS_PER_COUNT, vpc);
      write_register(CSR_AMPS_PER_VOLT, apv);
      write_register(CSR_LOAD_OHMS, ohms);
   endtask

   // One group of readings: flat extremes, pure noise, or a level with jitter
   task automatic send_group();
      int mode;
      int level;
      int jitter;
      int v;
      mode   = $urandom_range(9);
      level  = $urandom_range(4095);
      jitter = $urandom_range(64);
      for (int i = 0; i < OVERSAMPLE; i++) begin
         case (mode)
            0: v = 4095;
            1: v = 0;
            2, 3: v = $urandom_range(4095);
            default: v = level + $urandom_range(2 * jitter) - jitter;
         endcase
         if (v < 0) v = 0;
         if (v > 4095) v = 4095;
         send_sample(v[SAMPLE_W-1:0]);
      end
   endtask

   // Warm-up averages after reset, with every edge-case reading in one group
   task automatic test_directed_samples();
      for (int i = 15; i >= 0; i--)
         send_sample(EDGE_SAMPLES[i*SAMPLE_W +: SAMPLE_W]);
   endtask

   // A write to the spare index must leave all gains untouched
   task automatic test_unused_index();
      settle_pipeline();
      write_register(CSR_UNUSED, GAIN_MAX);
      send_group();
   endtask

   // All gains at zero: every product collapses to zero
   task automatic test_zero_gains();
      write_gains('0, '0, '0);
      send_group();
   endtask

   task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                      input logic [GAIN_W-1:0] vpc,
                                      input logic [GAIN_W-1:0] apv,
                                      input logic [GAIN_W-1:0] ohms);
      write_gains(vpc, apv, ohms);
      send_idle_pct = idle_pct;
      pop_stall_pct = stall_pct;
      repeat (GROUPS_PER_PHASE) send_group();
      send_idle_pct = 0;
      pop_stall_pct = 0;
   endtask

   // Pop at random according to the current stall rate
   always @(posedge clock)
      rsp_pop <= ($urandom_range(99) >= pop_stall_pct);

   // Check every popped transaction against the oldest expected reading
   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) begin
         readings_seen++;
         if (pending_readings.size() == 0) begin
            report_mismatch("reading popped with none expected");
         end else begin
            oldest_reading = pending_readings.pop_front();
            if (rsp_mean_raw !== oldest_reading.mean_raw)
               report_mismatch($sformatf("mean_raw %0h, expected %0h",
                               rsp_mean_raw, oldest_reading.mean_raw));
            if (rsp_sensed_volts !== oldest_reading.sensed_volts)
               report_mismatch($sformatf("sensed_volts %0h, expected %0h",
                               rsp_sensed_volts, oldest_reading.sensed_volts));
            if (rsp_filtered_current !== oldest_reading.filtered_current)
               report_mismatch($sformatf("filtered_current %0h, expected %0h",
                               rsp_filtered_current, oldest_reading.filtered_current));
            if (rsp_filtered_load_volts !== oldest_reading.filtered_load_volts)
               report_mismatch($sformatf("filtered_load_volts %0h, expected %0h",
                               rsp_filtered_load_volts,
                               oldest_reading.filtered_load_volts));
            if (rsp_power_estimate !== oldest_reading.power_estimate)
               report_mismatch($sformatf("power_estimate %0h, expected %0h",
                               rsp_power_estimate, oldest_reading.power_estimate));
         end
      end
   end

   initial begin
      reset_monitor_state();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_samples();
      test_unused_index();
      test_zero_gains();
      test_random_traffic(0, 0, GAIN_MAX, GAIN_MAX, GAIN_MAX);
      test_random_traffic(87, 0, GAIN_W'($urandom_range(24'hFFFFFF)), 24'd1, GAIN_MAX);
      test_random_traffic(0, 87, GAIN_MAX, GAIN_W'($urandom_range(24'hFFFFFF)), 24'd1);
      test_random_traffic(38, 38, GAIN_W'($urandom_range(24'hFFFFFF)),
                          GAIN_W'($urandom_range(24'hFFFFFF)),
                          GAIN_W'($urandom_range(24'hFFFFFF)));
      test_random_traffic(0, 0, VOLTS_PER_COUNT_RST, AMPS_PER_VOLT_RST, LOAD_OHMS_RST);

      settle_pipeline();
      $display("Sent %0d samples and checked %0d readings across %0d register writes,",
               samples_sent, readings_seen, reg_writes);
      $display("under no idling, sender gaps, receiver stalls and both together.");
      if (mismatch_count == 0)
         $display("** oversampled_power_monitor_core: PASSED **");
      else
         $display("** oversampled_power_monitor_core: FAILED **");
      $finish;
   end

endmodule
